>>> hw/rtl/fbd_pkg.sv
`timescale 1ns / 1ps

package fbd_pkg;

  localparam logic [15:0] WINDOW_RESET    = 16'd30;
  localparam logic [3:0]  THRESHOLD_RESET = 4'd3;
  localparam logic [3:0]  COUNT_MAX       = 4'd15;

  localparam logic REG_WINDOW    = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  // Token that walks the row of cells, one cell per cycle.
  typedef struct packed {
    logic        valid;
    logic        claim;
    logic [31:0] addr;
    logic [31:0] now;
    logic        hit;
    logic        free_seen;
    logic        alert;
    logic [3:0]  count;
    logic [31:0] start;
    logic [31:0] prev;
  } fbd_token_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_CLAIM  = 4'b0100,
    ST_FINISH = 4'b1000
  } fbd_state_t;

endpackage

>>> hw/rtl/fbd_cell.sv
`timescale 1ns / 1ps

module fbd_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        window,
  input  logic [3:0]         threshold,
  input  fbd_pkg::fbd_token_t tok_in,
  output fbd_pkg::fbd_token_t tok_out
);
  import fbd_pkg::*;

  logic        valid;
  logic [31:0] addr;
  logic [3:0]  count;
  logic [31:0] first;
  logic [31:0] last;

  logic        valid_next;
  logic [31:0] addr_next;
  logic [3:0]  count_next;
  logic [31:0] first_next;
  logic [31:0] last_next;
  fbd_token_t  tok_next;
  fbd_token_t  tok;

  logic signed [32:0] gap;
  logic               gap_ok;
  logic [3:0]         count_inc;

  assign gap       = $signed({1'b0, tok_in.now}) - $signed({1'b0, last});
  assign gap_ok    = gap <= $signed({17'b0, window});
  assign count_inc = (count < COUNT_MAX) ? count + 4'd1 : COUNT_MAX;

  always_comb begin
    tok_next   = tok_in;
    valid_next = valid;
    addr_next  = addr;
    count_next = count;
    first_next = first;
    last_next  = last;
    if (tok_in.valid) begin
      if (!tok_in.claim) begin
        if (valid && addr == tok_in.addr) begin
          tok_next.hit  = 1'b1;
          tok_next.prev = last;
          if (gap_ok) begin
            count_next     = count_inc;
            tok_next.count = count_inc;
            tok_next.start = first;
            if (count_inc >= threshold) begin
              tok_next.alert = 1'b1;
              valid_next     = 1'b0;
            end else begin
              last_next = tok_in.now;
            end
          end else begin
            count_next     = 4'd1;
            first_next     = tok_in.now;
            last_next      = tok_in.now;
            tok_next.count = 4'd1;
            tok_next.start = tok_in.now;
          end
        end else if (!valid) begin
          tok_next.free_seen = 1'b1;
        end
      end else if (!tok_in.hit && !valid) begin
        tok_next.hit   = 1'b1;
        tok_next.count = 4'd1;
        tok_next.start = tok_in.now;
        tok_next.prev  = 32'd0;
        valid_next     = 1'b1;
        addr_next      = tok_in.addr;
        count_next     = 4'd1;
        first_next     = tok_in.now;
        last_next      = tok_in.now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      tok.valid <= 1'b0;
    end else begin
      valid <= valid_next;
      tok   <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    addr  <= addr_next;
    count <= count_next;
    first <= first_next;
    last  <= last_next;
  end

  assign tok_out = tok;

endmodule

>>> hw/rtl/failed_login_burst_detector.sv
`timescale 1ns / 1ps
// An ignored event goes straight to the finish state; a known address or a dropped new address
// makes one search pass through the table, and a new address that claims an entry makes a
// search pass and then a claim pass.
// Throughput: one event at a time; the next can be taken in the cycle after the result is registered.
// The rate is set by the token walking the row of table cells, one cell per cycle.
// Reset (synchronous) empties the table and loads window 30 and threshold 3.

module failed_login_burst_detector #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // source_address [31:0], timestamp [63:32]
  input  logic        s_tuser,  // is_failed_login
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,  // alert [0], count [4:1], run_start_time [36:5],
                                // previous_time [68:37], table_full [69], zero [71:70]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fbd_pkg::*;

  logic [15:0] window;
  logic [3:0]  threshold;
  fbd_state_t  state;
  fbd_state_t  state_next;

  logic [31:0] evt_addr;
  logic [31:0] evt_now;

  logic        res_alert;
  logic [3:0]  res_count;
  logic [31:0] res_start;
  logic [31:0] res_prev;
  logic        res_full;

  fbd_token_t  chain [TABLE_ENTRIES + 1];
  fbd_token_t  tail;
  logic        go_search;
  logic        go_claim;
  logic        in_xfer;
  logic        out_free;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_THRESHOLD) ? {28'd0, threshold} : {16'd0, window};
  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign tail     = chain[TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= WINDOW_RESET;
      threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_WINDOW) begin
        window <= pwdata[15:0];
      end else begin
        threshold <= pwdata[3:0];
      end
    end
  end

  assign go_search = (state == ST_IDLE) && in_xfer && s_tuser;
  assign go_claim  = (state == ST_SEARCH) && tail.valid && !tail.hit && tail.free_seen;

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = go_search || go_claim;
    chain[0].claim = go_claim;
    chain[0].addr  = go_search ? s_tdata[31:0] : evt_addr;
    chain[0].now   = go_search ? s_tdata[63:32] : evt_now;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    fbd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .window    (window),
      .threshold (threshold),
      .tok_in    (chain[i]),
      .tok_out   (chain[i + 1])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = s_tuser ? ST_SEARCH : ST_FINISH;
        end
      end
      ST_SEARCH: begin
        if (tail.valid) begin
          state_next = go_claim ? ST_CLAIM : ST_FINISH;
        end
      end
      ST_CLAIM: begin
        if (tail.valid) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      evt_addr  <= s_tdata[31:0];
      evt_now   <= s_tdata[63:32];
      res_alert <= 1'b0;
      res_count <= 4'd0;
      res_start <= 32'd0;
      res_prev  <= 32'd0;
      res_full  <= 1'b0;
    end
    if ((state == ST_SEARCH || state == ST_CLAIM) && tail.valid && !go_claim) begin
      res_alert <= tail.alert;
      res_count <= tail.count;
      res_start <= tail.start;
      res_prev  <= tail.prev;
      res_full  <= !tail.hit;
    end
    if (state == ST_FINISH && out_free) begin
      m_tdata <= {2'b00, res_full, res_prev, res_start, res_count, res_alert};
    end
  end

endmodule

>>> hw/rtl/fbd_checker.sv
`timescale 1ns / 1ps

module fbd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  // One event is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an event is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // The first failure of a run never alerts, so an alert carries a count of two or more.
  a_alert_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[4:1] >= 4'd2 && !m_tdata[69])
    else $error("alert with a bad count or with table full");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[69] |-> m_tdata[68:1] == 68'd0)
    else $error("dropped event carries result fields");

endmodule

bind failed_login_burst_detector fbd_checker u_fbd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
